// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bspt_pkg.sv =====
package bspt_pkg;

  localparam int IDX_W           = 6;
  localparam int CNT_W           = 7;
  localparam int DIST_W          = 16;
  localparam int SUM_W           = DIST_W + 1;
  localparam int DEF_MAX_POINTS  = 64;
  localparam int RESULT_LIMIT    = 64;
  localparam int IN_TDATA_W      = 40;
  localparam int OUT_TDATA_W     = 24;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;      // input beat taken
    logic col_init;  // start a new column
    logic step;      // issue one pair of reads, advance k
    logic emit;      // load output register, advance column
  } bspt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic start_ok;   // input is a compute with a non-empty row
    logic col_short;  // column has no intermediate point
    logic k_last;     // current k is the last one of the column
    logic c_last;     // current column is the last of the row
    logic out_free;   // output register can take a result
  } bspt_stat_t;

endpackage

// ===== design/bspt_ram.sv =====
module bspt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== design/bspt_ctrl.sv =====
module bspt_ctrl
  import bspt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  bspt_stat_t stat,
  output bspt_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COL,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_tvalid;
        if (in_tvalid && stat.start_ok) begin
          state_nxt = S_COL;
        end
      end
      S_COL: begin
        cmd.col_init = 1'b1;
        state_nxt    = stat.col_short ? S_EMIT : S_SCAN;
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (stat.k_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last compare lands this cycle
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.c_last ? S_IDLE : S_COL;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/bspt_dp.sv =====
module bspt_dp
  import bspt_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bspt_cmd_t         cmd,
  output bspt_stat_t        stat,
  input  logic              operation,
  input  logic [IDX_W-1:0]  row_index,
  input  logic [IDX_W-1:0]  col_index,
  input  logic [DIST_W-1:0] distance,
  input  logic [CNT_W-1:0]  point_count,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [IDX_W-1:0]  out_row,
  output logic [IDX_W-1:0]  out_col,
  output logic [IDX_W-1:0]  split_point,
  output logic              out_last
);

  localparam int DEPTH  = MAX_POINTS * MAX_POINTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_LIM = (MAX_POINTS < RESULT_LIMIT) ? MAX_POINTS : RESULT_LIMIT;

  logic [IDX_W-1:0] row_r, c_r, k_r, best_r, cmp_k_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] bestsum_r;
  logic             cmp_vld_r;
  logic             out_vld_r;
  logic             out_last_r;
  logic [IDX_W-1:0] out_row_r, out_col_r, out_split_r;

  logic [CNT_W-1:0]  cnt_eff;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic [DIST_W-1:0] rd_a, rd_b;
  logic [SUM_W-1:0]  sum;

  assign cnt_eff = (32'(point_count) > CNT_LIM) ? CNT_W'(CNT_LIM) : point_count;

  assign wr_en = cmd.load && (operation == OP_WRITE) && (row_index < col_index) &&
                 (32'(col_index) < MAX_POINTS);

  assign wr_addr   = ADDR_W'(32'(row_index) * MAX_POINTS + 32'(col_index));
  // d(row,k) and d(k,c)
  assign rd_addr_a = ADDR_W'(32'(row_r) * MAX_POINTS + 32'(k_r));
  assign rd_addr_b = ADDR_W'(32'(k_r) * MAX_POINTS + 32'(c_r));

  bspt_ram #(
    .WIDTH (DIST_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (distance),
    .raddr_a (rd_addr_a),
    .rdata_a (rd_a),
    .raddr_b (rd_addr_b),
    .rdata_b (rd_b)
  );

  assign sum = SUM_W'(rd_a) + SUM_W'(rd_b);

  assign stat.start_ok  = (operation == OP_COMPUTE) && (cnt_eff >= CNT_W'(2)) &&
                          ({1'b0, row_index} < cnt_eff - CNT_W'(1));
  assign stat.col_short = ({1'b0, c_r} <= {1'b0, row_r} + CNT_W'(1));
  assign stat.k_last    = (k_r == c_r - IDX_W'(1));
  assign stat.c_last    = ({1'b0, c_r} == cnt_r - CNT_W'(1));
  assign stat.out_free  = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_r <= row_index;
      cnt_r <= cnt_eff;
      c_r   <= row_index;
    end
    if (cmd.col_init) begin
      best_r    <= c_r;
      bestsum_r <= '0;
      k_r       <= row_r + IDX_W'(1);
    end
    if (cmd.step) begin
      k_r     <= k_r + IDX_W'(1);
      cmp_k_r <= k_r;
    end
    // read data belongs to the k issued in the cycle before
    if (cmp_vld_r && (sum > bestsum_r)) begin
      bestsum_r <= sum;
      best_r    <= cmp_k_r;
    end
    if (cmd.emit) begin
      out_row_r   <= row_r;
      out_col_r   <= c_r;
      out_split_r <= best_r;
      out_last_r  <= stat.c_last;
      c_r         <= c_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.step;
      if (cmd.emit) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid  = out_vld_r;
  assign out_row     = out_row_r;
  assign out_col     = out_col_r;
  assign split_point = out_split_r;
  assign out_last    = out_last_r;

endmodule

// ===== design/best_split_point_table.sv =====
// Best split point table. Write beats (operation 0) load d(row,col) for row < col into
// a MAX_POINTS x MAX_POINTS distance store; other writes are dropped. A compute
// beat (operation 1) for row r and count n (limited to MAX_POINTS and 64) streams one result
// per column c = r..n-1, tlast on the final one; each gives the k with r < k < c of largest
// d(r,k)+d(k,c), first maximum winning, or c when no sum is above zero. A row at or beyond
// n-1 yields nothing. The store has one write and two read ports, so one (r,k)/(k,c) pair is
// scored per cycle: a column with c > r+1 goes through setup, one read pair per k, pipeline
// drain and result load; columns r and r+1 skip the reads. A result load waits while a
// result is still held downstream. Input is taken only between rows; results wait in an
// output register without holding up the next column's scan. The store has no reset:
// every entry must be written before a row reads it.
module best_split_point_table
  import bspt_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // row_index[5:0], col_index[11:6], distance[27:12], point_count[34:28]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // operation[0]
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_row[5:0], out_col[11:6], split_point[17:12]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

`include "assert_macros.svh"

  bspt_cmd_t        cmd;
  bspt_stat_t       stat;
  logic [IDX_W-1:0] out_row, out_col, split_point;

  bspt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bspt_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .operation   (in_tuser),
    .row_index   (in_tdata[5:0]),
    .col_index   (in_tdata[11:6]),
    .distance    (in_tdata[27:12]),
    .point_count (in_tdata[34:28]),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_row     (out_row),
    .out_col     (out_col),
    .split_point (split_point),
    .out_last    (out_tlast)
  );

  assign out_tdata = {(OUT_TDATA_W - 3 * IDX_W)'(0), split_point, out_col, out_row};

  `AST_IMP(a_emit_free, cmd.emit, !out_tvalid || out_tready, "result overwrote a pending beat")
  `AST_IMP(a_idle_no_scan, in_tready, !cmd.step && !cmd.emit, "input taken mid-row")
  `AST_NXT(a_start_busy, cmd.load && stat.start_ok, !in_tready, "compute beat not started")
  `AST_IMP(a_rose_emit, $rose(out_tvalid), $past(cmd.emit), "output valid without result")

endmodule

// ===== dv/tb.sv =====
module tb;
  import bspt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS         = DEF_MAX_POINTS;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int RAND_PER_PH  = 14;

  typedef struct {
    logic                op;
    logic [IDX_W-1:0]    row;
    logic [IDX_W-1:0]    col;
    logic [DIST_W-1:0]   dval;
    logic [CNT_W-1:0]    cnt;
  } beat_t;

  typedef struct {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] split;
    logic             last;
  } split_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
  typedef enum int {DS_FULL, DS_SMALL, DS_ZERO, DS_CONST, DS_EXTREME} dist_style_e;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  beat_t       pending_beats[$];
  split_t      expected_splits[$];
  beat_t       cur_beat;
  idle_mode_e  idle_mode = IDLE_NONE;
  int          fail_count = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          beats_pushed = 0;

  // distance store as seen by the block, and which entries the stimulus has loaded
  logic [DIST_W-1:0] dist_mem [NPTS][NPTS];
  bit                loaded   [NPTS][NPTS];

  always #5 clk = ~clk;

  best_split_point_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  function automatic logic [IN_TDATA_W-1:0] pack_beat(beat_t b);
    logic [IN_TDATA_W-1:0] v;
    v = '0;
    v[5:0]   = b.row;
    v[11:6]  = b.col;
    v[27:12] = b.dval;
    v[34:28] = b.cnt;
    return v;
  endfunction

  function automatic int limit_count(int cnt);
    int eff;
    eff = cnt;
    if (eff > NPTS) eff = NPTS;
    if (eff > RESULT_LIMIT) eff = RESULT_LIMIT;
    return eff;
  endfunction

  // expected results for one accepted beat
  task automatic predict_beat(beat_t b);
    int     r, eff, best;
    logic [SUM_W-1:0] sum, best_sum;
    split_t res;
    r = b.row;
    if (b.op == OP_WRITE) begin
      if (b.row < b.col) dist_mem[b.row][b.col] = b.dval;
      return;
    end
    eff = limit_count(b.cnt);
    if (eff < 2 || r >= eff - 1) return;
    for (int c = r; c < eff; c++) begin
      best = c;
      best_sum = '0;
      for (int k = r + 1; k < c; k++) begin
        sum = SUM_W'(dist_mem[r][k]) + SUM_W'(dist_mem[k][c]);
        if (sum > best_sum) begin
          best_sum = sum;
          best = k;
        end
      end
      res.row   = IDX_W'(r);
      res.col   = IDX_W'(c);
      res.split = IDX_W'(best);
      res.last  = (c == eff - 1);
      expected_splits.push_back(res);
    end
  endtask

  function automatic logic [DIST_W-1:0] draw_dist(dist_style_e style);
    case (style)
      DS_SMALL: return DIST_W'($urandom_range(0, 3));
      DS_ZERO:  return '0;
      DS_CONST: return DIST_W'(7);
      DS_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return 16'hfffe;
          default: return 16'h0001;
        endcase
      end
      default: return DIST_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic push_write(int r, int c, logic [DIST_W-1:0] d);
    beat_t b;
    b.op   = OP_WRITE;
    b.row  = IDX_W'(r);
    b.col  = IDX_W'(c);
    b.dval = d;
    b.cnt  = CNT_W'($urandom_range(0, 127));
    if (b.row < b.col) loaded[b.row][b.col] = 1'b1;
    pending_beats.push_back(b);
    beats_pushed++;
  endtask

  task automatic fill_window(int lo, int hi, dist_style_e style);
    for (int i = lo; i < hi; i++)
      for (int j = i + 1; j < hi; j++)
        push_write(i, j, draw_dist(style));
  endtask

  // loads whatever the row will read and is still unwritten, then the compute beat
  task automatic push_compute(int r, int cnt);
    int    eff;
    beat_t b;
    eff = limit_count(cnt);
    if (eff >= 2 && r < eff - 1)
      for (int i = r; i < eff; i++)
        for (int j = i + 1; j < eff; j++)
          if (!loaded[i][j]) push_write(i, j, draw_dist(DS_FULL));
    b.op   = OP_COMPUTE;
    b.row  = IDX_W'(r);
    b.col  = IDX_W'($urandom_range(0, 63));
    b.dval = DIST_W'($urandom_range(0, 65535));
    b.cnt  = CNT_W'(cnt);
    pending_beats.push_back(b);
    beats_pushed++;
  endtask

  task automatic random_items(int n);
    int kind, lo, cnt, span, eff, start;
    start = beats_pushed;
    while (beats_pushed - start < n) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        if ($urandom_range(0, 9) == 0) begin
          // saturated count, row near the top
          lo  = $urandom_range(NPTS - 6, NPTS - 2);
          cnt = $urandom_range(NPTS, 127);
        end else begin
          span = $urandom_range(2, 6);
          lo   = $urandom_range(0, NPTS - span);
          cnt  = lo + span;
        end
        if ($urandom_range(0, 9) < 5)
          fill_window(lo, limit_count(cnt), dist_style_e'($urandom_range(0, 4)));
        push_compute(lo, cnt);
      end else if (kind <= 7) begin
        push_write($urandom_range(0, 63), $urandom_range(0, 63),
                   draw_dist(dist_style_e'($urandom_range(0, 4))));
      end else if (kind == 8) begin
        // row at or past count-1: nothing comes back
        cnt = $urandom_range(0, 127);
        eff = limit_count(cnt);
        lo  = $urandom_range((eff < 2) ? 0 : eff - 1, 63);
        push_compute(lo, cnt);
      end else begin
        cnt = $urandom_range(0, 127);
        eff = limit_count(cnt);
        lo  = $urandom_range((eff > 6) ? eff - 6 : 0, 63);
        push_compute(lo, cnt);
      end
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_beat(cur_beat);
      if (!in_tvalid || in_tready) begin
        if (pending_beats.size() > 0 &&
            !((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) &&
              $urandom_range(0, 99) < 82)) begin
          cur_beat = pending_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= pack_beat(cur_beat);
          in_tuser  <= cur_beat.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    split_t exp_res;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_splits.size() == 0) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result beat: tdata=%h tlast=%b", out_tdata, out_tlast);
        end else begin
          exp_res = expected_splits.pop_front();
          if (out_tdata[5:0] !== exp_res.row || out_tdata[11:6] !== exp_res.col ||
              out_tdata[17:12] !== exp_res.split || out_tlast !== exp_res.last) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp row=%0d col=%0d split=%0d last=%b,",
                       exp_res.row, exp_res.col, exp_res.split, exp_res.last,
                       " got row=%0d col=%0d split=%0d last=%b",
                       out_tdata[5:0], out_tdata[11:6], out_tdata[17:12], out_tlast);
          end
        end
      end
      out_tready <= !((idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH) &&
                      $urandom_range(0, 99) < 82);
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("best_split_point_table verification failed");
    $finish;
  end

  initial begin
    foreach (dist_mem[i, j]) begin
      dist_mem[i][j] = '0;
      loaded[i][j]   = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: dropped writes, empty rows, saturation, zero sums, ties, wide sums
    push_write(5, 5, 16'hffff);
    push_write(40, 3, 16'h1234);
    push_compute(0, 0);
    push_compute(7, 1);
    push_compute(63, 64);
    push_compute(62, 127);
    push_compute(0, 2);
    fill_window(10, 14, DS_ZERO);
    push_compute(10, 14);
    fill_window(20, 24, DS_CONST);
    push_compute(20, 24);
    fill_window(40, 44, DS_EXTREME);
    push_compute(40, 44);
    push_write(62, 63, 16'h0000);
    push_compute(59, 100);
    push_compute(60, 64);

    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = idle_mode_e'(ph);
      random_items(RAND_PER_PH);
      while (pending_beats.size() > 0) @(negedge clk);
    end

    idle_mode = IDLE_NONE;
    while (pending_beats.size() > 0 || in_tvalid || expected_splits.size() > 0)
      @(negedge clk);
    // a compute with no expected results never leaves idle; this wait lets stray result beats show up
    repeat (100) @(negedge clk);

    if (expected_splits.size() > 0) begin
      fail_count++;
      $display("%0d expected results never arrived", expected_splits.size());
    end
    if (fail_count == 0) begin
      $display("best_split_point_table verification clean");
    end else begin
      $display("best_split_point_table verification failed");
    end
    $finish;
  end

endmodule
